### sv/hlt_pkg.sv
// Shared types and constants for the host address learning table.
// No dependencies.
`default_nettype none
package hlt_pkg;

  localparam int MAC_W     = 48;
  localparam int IP_W      = 64;
  localparam int V4_W      = 32;
  localparam int ST_W      = 3;
  localparam int OIDX_W    = 6;
  // Widest host index and list count over the legal parameter ranges
  localparam int TIDX_W    = 10;
  localparam int TCNT_W    = 7;

  typedef enum logic [ST_W-1:0] {
    ST_KNOWN      = 3'd0,
    ST_ADDED      = 3'd1,
    ST_NEW        = 3'd2,
    ST_HOSTS_FULL = 3'd3,
    ST_LIST_FULL  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAUNCH,
    S_SEARCH,
    S_READ,
    S_CMP,
    S_APPEND,
    S_OUT
  } state_t;

  // Lookup token handed from cell to cell
  typedef struct packed {
    logic              act;
    logic              found;
    logic [TIDX_W-1:0] idx;
    logic [TCNT_W-1:0] v4c;
    logic [TCNT_W-1:0] v6c;
  } tok_t;

  // Host entry write broadcast to the cells
  typedef struct packed {
    logic              we;
    logic              set_mac;
    logic [TIDX_W-1:0] idx;
    logic [MAC_W-1:0]  mac;
    logic [TCNT_W-1:0] v4c;
    logic [TCNT_W-1:0] v6c;
  } upd_t;

endpackage
`default_nettype wire

### sv/hlt_cell.sv
// One host cell: MAC, per-kind address counts and the lookup token stage.
// Depends on hlt_pkg.
`default_nettype none
module hlt_cell
  import hlt_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [MAC_W-1:0] key_mac,
  input  wire tok_t             tok_i,
  output tok_t                  tok_o,
  input  wire upd_t             upd
);

  logic              valid_r;
  logic [MAC_W-1:0]  mac_r;
  logic [TCNT_W-1:0] v4c_r;
  logic [TCNT_W-1:0] v6c_r;
  tok_t              tok_r, tok_nxt;
  logic              sel;

  assign sel = upd.we && (upd.idx == TIDX_W'(IDX));

  always_comb begin
    tok_nxt = tok_i;
    if (tok_i.act && !tok_i.found && valid_r && (mac_r == key_mac)) begin
      tok_nxt.found = 1'b1;
      tok_nxt.idx   = TIDX_W'(IDX);
      tok_nxt.v4c   = v4c_r;
      tok_nxt.v6c   = v6c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      v4c_r   <= '0;
      v6c_r   <= '0;
      tok_r   <= '0;
    end else begin
      tok_r <= tok_nxt;
      if (sel) begin
        v4c_r <= upd.v4c;
        v6c_r <= upd.v6c;
        if (upd.set_mac) begin
          valid_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel && upd.set_mac) begin
      mac_r <= upd.mac;
    end
  end

  assign tok_o = tok_r;

endmodule
`default_nettype wire

### sv/host_address_learning_table.sv
// Top level of the host address learning table: cell chain, address stores, sequencer.
// Depends on hlt_pkg and hlt_cell.
//
//  channel | ports          | tdata (low bit up)                 | tuser
//  --------+----------------+------------------------------------+--------------
//  in      | in_t*          | mac[47:0] ip_low[111:48]           | req_type
//          |                | ip_high[175:112]                   |
//  out     | out_t*         | status[2:0] host_index[8:3], 0 pad | -
//
// Throughput: one request at a time. From accept to result the token walks through the
//   MAX_HOSTS cells, and the matched host's list of the requested kind is then read one
//   entry at a time through the one read port of its address store.
// Reset: clears host count, cell valid bits and counts; the address stores are not cleared.
// Stalls: a held result does not block the next accept; the sequencer only waits for
//   the output register before loading the next result.
`default_nettype none
module host_address_learning_table
  import hlt_pkg::*;
#(
  parameter int MAX_HOSTS       = 64,
  parameter int MAX_V4_PER_HOST = 8,
  parameter int MAX_V6_PER_HOST = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [175:0] in_tdata,   // mac, ip_low, ip_high
  input  wire logic [0:0]   in_tuser,   // req_type
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [15:0]       out_tdata   // status, host_index, zero pad
);

  localparam int HW   = $clog2(MAX_HOSTS);
  localparam int CW   = $clog2(MAX_HOSTS + 1);
  localparam int MAXL = (MAX_V4_PER_HOST > MAX_V6_PER_HOST) ? MAX_V4_PER_HOST
                                                            : MAX_V6_PER_HOST;
  localparam int LW   = $clog2(MAXL + 1);
  localparam int D4   = MAX_HOSTS * MAX_V4_PER_HOST;
  localparam int D6   = MAX_HOSTS * MAX_V6_PER_HOST;
  localparam int A4W  = (D4 > 1) ? $clog2(D4) : 1;
  localparam int A6W  = (D6 > 1) ? $clog2(D6) : 1;
  localparam logic [LW-1:0] LIM4 = LW'(MAX_V4_PER_HOST);
  localparam logic [LW-1:0] LIM6 = LW'(MAX_V6_PER_HOST);

  state_t             state_r, state_nxt;
  logic [CW-1:0]      hcnt_r, hcnt_nxt;
  logic               type_r;
  logic [MAC_W-1:0]   mac_r;
  logic [IP_W-1:0]    lo_r, hi_r;
  logic [HW-1:0]      idx_r, res_idx_r;
  status_t            res_status_r;
  logic [LW-1:0]      cnt_r, k_r;
  logic [TCNT_W-1:0]  v4c_r, v6c_r;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [ST_W-1:0]    out_status_r;
  logic [OIDX_W-1:0]  out_idx_r;

  tok_t               chain [MAX_HOSTS+1];
  tok_t               tail;
  upd_t               upd;

  logic [V4_W-1:0]    mem4 [D4];
  logic [2*IP_W-1:0]  mem6 [D6];
  logic [V4_W-1:0]    rd4_q;
  logic [2*IP_W-1:0]  rd6_q;
  logic               we4, we6, re;
  logic [HW-1:0]      base_idx;
  logic [LW-1:0]      off;
  logic [A4W-1:0]     addr4;
  logic [A6W-1:0]     addr6;
  logic               hit, full, out_free;
  logic [LW-1:0]      lim, tail_cnt;

  // Lookup chain: the token enters cell 0 in S_LAUNCH and moves one cell a cycle
  always_comb begin
    chain[0]     = '0;
    chain[0].act = (state_r == S_LAUNCH);
  end

  for (genvar i = 0; i < MAX_HOSTS; i++) begin : g_cell
    hlt_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .key_mac (mac_r),
      .tok_i   (chain[i]),
      .tok_o   (chain[i+1]),
      .upd     (upd)
    );
  end

  assign tail     = chain[MAX_HOSTS];
  assign full     = (hcnt_r == CW'(MAX_HOSTS));
  assign lim      = type_r ? LIM6 : LIM4;
  assign tail_cnt = type_r ? LW'(tail.v6c) : LW'(tail.v4c);
  assign hit      = type_r ? (rd6_q == {hi_r, lo_r}) : (rd4_q == lo_r[V4_W-1:0]);
  assign out_free = !out_tvalid_r || out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_LAUNCH;
      S_LAUNCH: state_nxt = S_SEARCH;
      S_SEARCH: begin
        if (tail.act) begin
          if (!tail.found) state_nxt = S_OUT;
          else if (tail_cnt == '0) state_nxt = S_APPEND;
          else state_nxt = S_READ;
        end
      end
      S_READ:   state_nxt = S_CMP;
      S_CMP: begin
        if (hit) state_nxt = S_OUT;
        else if (LW'(k_r + LW'(1)) == cnt_r) state_nxt = S_APPEND;
        else state_nxt = S_READ;
      end
      S_APPEND: state_nxt = S_OUT;
      S_OUT:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs: cell writes, store enables, host count
  always_comb begin
    in_tready = 1'b0;
    upd       = '0;
    upd.mac   = mac_r;
    we4       = 1'b0;
    we6       = 1'b0;
    re        = 1'b0;
    base_idx  = idx_r;
    off       = cnt_r;
    hcnt_nxt  = hcnt_r;
    case (state_r)
      S_IDLE: in_tready = 1'b1;
      S_SEARCH: begin
        base_idx = hcnt_r[HW-1:0];
        off      = '0;
        if (tail.act && !tail.found && !full) begin
          upd.we      = 1'b1;
          upd.set_mac = 1'b1;
          upd.idx     = TIDX_W'(hcnt_r);
          upd.v4c     = type_r ? TCNT_W'(0) : TCNT_W'(1);
          upd.v6c     = type_r ? TCNT_W'(1) : TCNT_W'(0);
          we4         = !type_r;
          we6         = type_r;
          hcnt_nxt    = CW'(hcnt_r + CW'(1));
        end
      end
      S_READ: begin
        off = k_r;
        re  = 1'b1;
      end
      S_APPEND: begin
        if (cnt_r != lim) begin
          upd.we  = 1'b1;
          upd.idx = TIDX_W'(idx_r);
          upd.v4c = type_r ? v4c_r : TCNT_W'(cnt_r) + TCNT_W'(1);
          upd.v6c = type_r ? TCNT_W'(cnt_r) + TCNT_W'(1) : v6c_r;
          we4     = !type_r;
          we6     = type_r;
        end
      end
      default: ;
    endcase
  end

  assign addr4 = A4W'(A4W'(base_idx) * A4W'(MAX_V4_PER_HOST)) + A4W'(off);
  assign addr6 = A6W'(A6W'(base_idx) * A6W'(MAX_V6_PER_HOST)) + A6W'(off);

  // Address stores, one port each, registered read
  always_ff @(posedge clk) begin
    if (we4) mem4[addr4] <= lo_r[V4_W-1:0];
    if (re)  rd4_q <= mem4[addr4];
  end

  always_ff @(posedge clk) begin
    if (we6) mem6[addr6] <= {hi_r, lo_r};
    if (re)  rd6_q <= mem6[addr6];
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (state_r == S_OUT && out_free) out_tvalid_nxt = 1'b1;
    else if (out_tready) out_tvalid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      hcnt_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      hcnt_r       <= hcnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Request, lookup and result payload
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          type_r <= in_tuser[0];
          mac_r  <= in_tdata[47:0];
          lo_r   <= in_tdata[111:48];
          hi_r   <= in_tdata[175:112];
        end
      end
      S_SEARCH: begin
        if (tail.act) begin
          k_r   <= '0;
          cnt_r <= tail_cnt;
          v4c_r <= tail.v4c;
          v6c_r <= tail.v6c;
          idx_r <= tail.idx[HW-1:0];
          if (!tail.found) begin
            if (full) begin
              res_status_r <= ST_HOSTS_FULL;
              res_idx_r    <= '0;
            end else begin
              res_status_r <= ST_NEW;
              res_idx_r    <= hcnt_r[HW-1:0];
            end
          end
        end
      end
      S_CMP: begin
        k_r <= LW'(k_r + LW'(1));
        if (hit) begin
          res_status_r <= ST_KNOWN;
          res_idx_r    <= idx_r;
        end
      end
      S_APPEND: begin
        res_status_r <= (cnt_r == lim) ? ST_LIST_FULL : ST_ADDED;
        res_idx_r    <= idx_r;
      end
      S_OUT: begin
        if (out_free) begin
          out_status_r <= res_status_r;
          out_idx_r    <= OIDX_W'(res_idx_r);
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, out_idx_r, out_status_r};

endmodule
`default_nettype wire

### sv/hlt_checker.sv
// Port-level checks for the host address learning table, bound to the top level.
// Depends on hlt_pkg and host_address_learning_table.
`default_nettype none
module hlt_checker
  import hlt_pkg::*;
(
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [15:0]  out_tdata
);

  logic in_beat;
  assign in_beat = in_tvalid && in_tready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("held result beat changed");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= ST_LIST_FULL)
    else $error("status code out of range");

  a_full_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == ST_HOSTS_FULL |-> out_tdata[8:3] == 6'd0)
    else $error("host index not zero on full table");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> !in_tready && !$rose(out_tvalid))
    else $error("request accepted while lookup in progress");

endmodule

bind host_address_learning_table hlt_checker u_hlt_checker (.*);
`default_nettype wire
